// ===== rtl/sst_pkg.sv =====
`default_nettype none

package sst_pkg;

	typedef enum logic [1:0] {
		OP_ADD     = 2'd0,
		OP_TICK    = 2'd1,
		OP_SERVICE = 2'd2,
		OP_SET_EN  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		EV_ADDED = 2'd0,
		EV_FIRED = 2'd1,
		EV_FULL  = 2'd2
	} event_kind_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_DONE = 3'b100
	} state_t;

	// one timer slot as it travels around the ring
	typedef struct packed {
		logic        valid;
		logic        enabled;
		logic        action;
		logic [31:0] remaining;
		logic [31:0] period;
	} slot_t;

	// what the head did to the slot passing through it
	typedef struct packed {
		logic claim;
		logic fire;
	} head_flags_t;

	localparam logic [4:0] MAX_REPORTS = 5'd16;

endpackage

`default_nettype wire

// ===== rtl/software_timer_table.sv =====
// Timer slot table. The slots live in a ring of SLOTS cells that rotates
// one position per cycle while a request runs, holding while a fired
// slot's result waits on a stalled output; the cell at the head of the
// ring applies the request to the slot passing through it, so every request
// makes one full turn of the ring. A request passes through acceptance,
// SLOTS head steps, one closing step and any result stall before the
// next can be taken. Add answers with one result after the turn; service
// reports fired slots in index order, at most sixteen per request, with
// last_event on the final one; tick and set enable give no result.
// event_slot carries the low four bits of the slot index.
`default_nettype none

module software_timer_table
	import sst_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] initial_delay,
	input  wire logic [31:0] reload_period,
	input  wire logic        has_action,
	input  wire logic [3:0]  target_slot,
	input  wire logic        enable_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       event_kind,
	output logic [3:0]       event_slot,
	output logic             last_event
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	state_t      state_q;
	logic [IW-1:0] step_q;
	opcode_t     op_q;
	logic [31:0] delay_q;
	logic [31:0] period_q;
	logic        act_q;
	logic [3:0]  target_q;
	logic        en_q;

	logic          found_q;
	logic [IW-1:0] found_idx_q;
	logic          pend_q;
	logic [IW-1:0] pend_idx_q;
	logic [4:0]    rep_q;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [3:0]  slot_q;
	logic        last_q;

	slot_t       ring [SLOTS];
	slot_t       head_nxt;
	head_flags_t flags;

	logic accept, out_free, report, emit_req, advance, shift;
	logic out_load;
	logic [1:0] kind_d;
	logic [3:0] slot_d;
	logic       last_d;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	sst_head u_head (
		.op            (op_q),
		.cur           (ring[0]),
		.claim_ok      (!found_q),
		.is_target     (7'(step_q) == 7'(target_q)),
		.initial_delay (delay_q),
		.reload_period (period_q),
		.has_action    (act_q),
		.enable_value  (en_q),
		.nxt           (head_nxt),
		.flags         (flags)
	);

	// a fired slot beyond the report limit is serviced but not reported
	assign report   = flags.fire && (rep_q < MAX_REPORTS);
	assign emit_req = report && pend_q;
	assign advance  = (state_q == S_RUN) && (!emit_req || out_free);
	assign shift    = advance;

	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		slot_t d;
		if (k == SLOTS - 1) begin : g_tail
			assign d = head_nxt;
		end else begin : g_mid
			assign d = ring[k+1];
		end
		sst_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      (d),
			.q      (ring[k])
		);
	end

	always_comb begin
		out_load = 1'b0;
		kind_d   = EV_FIRED;
		slot_d   = 4'(pend_idx_q);
		last_d   = 1'b0;
		case (state_q)
			S_RUN: begin
				if (advance && emit_req)
					out_load = 1'b1;
			end
			S_DONE: begin
				if (op_q == OP_ADD) begin
					out_load = out_free;
					kind_d   = found_q ? EV_ADDED : EV_FULL;
					slot_d   = found_q ? 4'(found_idx_q) : 4'd0;
					last_d   = 1'b1;
				end else if (op_q == OP_SERVICE && pend_q) begin
					out_load = out_free;
					last_d   = 1'b1;
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			found_q <= 1'b0;
			pend_q  <= 1'b0;
			rep_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RUN;
						step_q  <= '0;
						found_q <= 1'b0;
						pend_q  <= 1'b0;
						rep_q   <= '0;
					end
				end
				S_RUN: begin
					if (advance) begin
						if (flags.claim)
							found_q <= 1'b1;
						if (report) begin
							pend_q <= 1'b1;
							rep_q  <= rep_q + 5'd1;
						end
						if (step_q == IW'(SLOTS - 1))
							state_q <= S_DONE;
						else
							step_q <= step_q + 1'b1;
					end
				end
				S_DONE: begin
					if (out_load || !((op_q == OP_ADD) || (op_q == OP_SERVICE && pend_q)))
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= opcode_t'(opcode);
			delay_q  <= initial_delay;
			period_q <= reload_period;
			act_q    <= has_action;
			target_q <= target_slot;
			en_q     <= enable_value;
		end
		if (advance && flags.claim)
			found_idx_q <= step_q;
		if (advance && report)
			pend_idx_q <= step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q <= kind_d;
			slot_q <= slot_d;
			last_q <= last_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = kind_q;
	assign event_slot = slot_q;
	assign last_event = last_q;

endmodule

`default_nettype wire

// ===== rtl/sst_cell.sv =====
`default_nettype none

module sst_cell
	import sst_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  shift,
	input  wire slot_t d,
	output slot_t      q
);

	logic        valid_q;
	logic        enabled_q;
	logic        action_q;
	logic [31:0] remaining_q;
	logic [31:0] period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			enabled_q <= 1'b0;
			action_q  <= 1'b0;
		end else if (shift) begin
			valid_q   <= d.valid;
			enabled_q <= d.enabled;
			action_q  <= d.action;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			remaining_q <= d.remaining;
			period_q    <= d.period;
		end
	end

	assign q = '{valid: valid_q, enabled: enabled_q, action: action_q,
		remaining: remaining_q, period: period_q};

endmodule

`default_nettype wire

// ===== rtl/sst_head.sv =====
`default_nettype none

module sst_head
	import sst_pkg::*;
(
	input  wire opcode_t     op,
	input  wire slot_t       cur,
	input  wire logic        claim_ok,
	input  wire logic        is_target,
	input  wire logic [31:0] initial_delay,
	input  wire logic [31:0] reload_period,
	input  wire logic        has_action,
	input  wire logic        enable_value,
	output slot_t            nxt,
	output head_flags_t      flags
);

	always_comb begin
		nxt   = cur;
		flags = '0;
		case (op)
			OP_ADD: begin
				if (claim_ok && !cur.valid) begin
					nxt.valid     = 1'b1;
					nxt.enabled   = 1'b0;
					nxt.action    = has_action;
					nxt.remaining = initial_delay;
					nxt.period    = reload_period;
					flags.claim   = 1'b1;
				end
			end
			OP_TICK: begin
				if (cur.valid && cur.enabled && cur.remaining != 32'd0)
					nxt.remaining = cur.remaining - 32'd1;
			end
			OP_SERVICE: begin
				if (cur.valid && cur.action && cur.remaining == 32'd0) begin
					flags.fire = 1'b1;
					if (cur.period != 32'd0) begin
						nxt.remaining = cur.period;
					end else begin
						// one-shot: free the slot
						nxt.valid   = 1'b0;
						nxt.enabled = 1'b0;
						nxt.action  = 1'b0;
					end
				end
			end
			OP_SET_EN: begin
				if (is_target && cur.valid)
					nxt.enabled = enable_value;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/sst_checker.sv =====
`default_nettype none

module sst_checker
	import sst_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  event_kind,
	input wire logic [3:0]  event_slot,
	input wire logic        last_event
);

	// one request at a time: the table is busy right after taking one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one still running");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_kind) &&
			$stable(event_slot) && $stable(last_event))
		else $error("stalled result changed");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_kind != 2'd3)
		else $error("unknown event kind");

	a_full_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_FULL |-> event_slot == 4'd0 && last_event)
		else $error("table-full result malformed");

	a_add_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_ADDED |-> last_event)
		else $error("add result not marked last");

endmodule

bind software_timer_table sst_checker u_sst_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.event_kind (event_kind),
	.event_slot (event_slot),
	.last_event (last_event)
);

`default_nettype wire
